>>> rtl/m3mv_pkg.sv
// Shared types and constants for the mod-3 matrix times binary vector block.
// Stream field layout, operation codes, sequencer states, accumulator control and the mod-3 add.
// No dependencies.
package m3mv_pkg;

  localparam int COLUMNS_DEF = 256;
  localparam int ROWS_DEF    = 81;
  localparam int WORD_BITS   = 64;
  localparam int VEC_BITS    = 256;
  localparam int HIGH_BITS   = 17;
  localparam int COL_BITS    = 8;

  // input item layout in s_axis_tdata
  localparam int COL_LSB   = 0;
  localparam int HALF_LSB  = COL_LSB + COL_BITS;
  localparam int TWOS_LSB  = HALF_LSB + 1;
  localparam int ONES_LSB  = TWOS_LSB + WORD_BITS;
  localparam int VEC_LSB   = ONES_LSB + WORD_BITS;
  localparam int S_USED    = VEC_LSB + VEC_BITS;
  localparam int S_TDATA_W = ((S_USED + 7) / 8) * 8;

  // result item layout in m_axis_tdata
  localparam int RTL_LSB   = 0;
  localparam int RTH_LSB   = RTL_LSB + WORD_BITS;
  localparam int ROL_LSB   = RTH_LSB + HIGH_BITS;
  localparam int ROH_LSB   = ROL_LSB + WORD_BITS;
  localparam int M_USED    = ROH_LSB + HIGH_BITS;
  localparam int M_TDATA_W = ((M_USED + 7) / 8) * 8;

  typedef enum logic {
    OP_LOAD = 1'b0,
    OP_EVAL = 1'b1
  } opcode_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_WALK,
    ST_FLUSH,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic clear;
    logic en;
    logic sel;
  } acc_ctrl_t;

  // bit-sliced mod-3 sum; twos plane m, ones plane l; returns {twos, ones}
  function automatic logic [2*WORD_BITS-1:0] trit_add(
    input logic [WORD_BITS-1:0] m1,
    input logic [WORD_BITS-1:0] l1,
    input logic [WORD_BITS-1:0] m2,
    input logic [WORD_BITS-1:0] l2
  );
    logic [WORD_BITS-1:0] t;
    t = (l1 | m2) ^ (l2 | m1);
    return {(l1 | l2) ^ t, (m1 | m2) ^ t};
  endfunction

endpackage

>>> rtl/m3mv_ram.sv
// Generic single-write, single-read synchronous RAM with registered read data.
// No dependencies.
module m3mv_ram #(
  parameter int WIDTH = 128,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

>>> rtl/m3mv_accum.sv
// Mod-3 row accumulator for both row halves, one column added per enabled cycle.
// Depends on m3mv_pkg.
module m3mv_accum (
  input  logic                                clk,
  input  m3mv_pkg::acc_ctrl_t                 ctrl,
  input  logic [2*m3mv_pkg::WORD_BITS-1:0]    lo_col,
  input  logic [2*m3mv_pkg::WORD_BITS-1:0]    hi_col,
  output logic [m3mv_pkg::WORD_BITS-1:0]      twos_lo,
  output logic [m3mv_pkg::WORD_BITS-1:0]      twos_hi,
  output logic [m3mv_pkg::WORD_BITS-1:0]      ones_lo,
  output logic [m3mv_pkg::WORD_BITS-1:0]      ones_hi
);

  localparam int W = m3mv_pkg::WORD_BITS;

  logic [W-1:0]   sel_mask;
  logic [2*W-1:0] sum_lo;
  logic [2*W-1:0] sum_hi;

  // column words are {ones, twos}
  assign sel_mask = {W{ctrl.sel}};
  assign sum_lo = m3mv_pkg::trit_add(twos_lo, ones_lo,
                                     lo_col[W-1:0] & sel_mask, lo_col[2*W-1:W] & sel_mask);
  assign sum_hi = m3mv_pkg::trit_add(twos_hi, ones_hi,
                                     hi_col[W-1:0] & sel_mask, hi_col[2*W-1:W] & sel_mask);

  always_ff @(posedge clk) begin
    if (ctrl.clear) begin
      twos_lo <= '0;
      ones_lo <= '0;
      twos_hi <= '0;
      ones_hi <= '0;
    end else if (ctrl.en) begin
      twos_lo <= sum_lo[2*W-1:W];
      ones_lo <= sum_lo[W-1:0];
      twos_hi <= sum_hi[2*W-1:W];
      ones_hi <= sum_hi[W-1:0];
    end
  end

endmodule

>>> rtl/mod3_matrix_binary_vector_top.sv
// Top level of the mod-3 matrix times binary vector block: stream ports, column
// sequencer, load masking, two column RAMs and the mod-3 accumulator.
// Depends on m3mv_pkg, m3mv_ram and m3mv_accum.
//
// Usage:
//   Slave channel s_axis takes items. tuser is the operation: load writes one
//   row half of one column (rows 0-63 or rows 64 up), evaluate brings the
//   binary vector. A load entry with both bits set is stored as zero, and rows
//   past ROWS are stored as zero; a column past COLUMNS is ignored.
//   Master channel m_axis returns one item per evaluate: the result trits as
//   twos and ones planes. A load returns nothing.
//   An evaluate walks min(COLUMNS, 256) columns, one RAM read and one mod-3
//   accumulate a cycle, set by the single RAM read port.
//   The result item is loaded after the walk, a flush state and a done state;
//   the next item can be taken in the same cycle that the result turns valid.
//   s_axis_tready is high only while no evaluate is in progress.
//   The result sits in an output register; the next item is taken while it
//   waits, but a following evaluate holds in its last state until it is taken.
//   Reset clears the sequencer and the output valid; the matrix is undefined
//   until every column half has been loaded.
module mod3_matrix_binary_vector_top #(
  parameter int COLUMNS = m3mv_pkg::COLUMNS_DEF,
  parameter int ROWS    = m3mv_pkg::ROWS_DEF
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           s_axis_tvalid,
  output logic                           s_axis_tready,
  // column_index, row_half, twos_word, ones_word, vector_word0..3, zero pad
  input  logic [m3mv_pkg::S_TDATA_W-1:0] s_axis_tdata,
  // opcode
  input  logic [0:0]                     s_axis_tuser,
  output logic                           m_axis_tvalid,
  input  logic                           m_axis_tready,
  // result_twos_low, result_twos_high, result_ones_low, result_ones_high, zero pad
  output logic [m3mv_pkg::M_TDATA_W-1:0] m_axis_tdata
);

  localparam int W      = m3mv_pkg::WORD_BITS;
  localparam int HB     = m3mv_pkg::HIGH_BITS;
  localparam int MW     = m3mv_pkg::M_TDATA_W;
  localparam int ADDR_W = $clog2(COLUMNS);
  localparam int WALK   = (COLUMNS < m3mv_pkg::VEC_BITS) ? COLUMNS : m3mv_pkg::VEC_BITS;
  localparam int CNT_W  = $clog2(WALK);

  m3mv_pkg::state_t    state, state_next;
  m3mv_pkg::acc_ctrl_t acc_ctrl;

  logic [CNT_W-1:0]                cnt;
  logic [m3mv_pkg::VEC_BITS-1:0]   vec;
  logic                            rd_valid;
  logic                            rd_sel;
  logic                            accept;
  logic                            load_fire;
  logic                            eval_start;
  logic                            out_load;

  logic [m3mv_pkg::COL_BITS-1:0]   col;
  logic                            half;
  logic [W-1:0]                    tw_in;
  logic [W-1:0]                    on_in;
  logic [W-1:0]                    lo_mask;
  logic [W-1:0]                    hi_mask;
  logic                            col_ok;
  logic [ADDR_W-1:0]               waddr;
  logic [2*W-1:0]                  lo_wdata;
  logic [2*W-1:0]                  hi_wdata;
  logic [2*W-1:0]                  lo_rdata;
  logic [2*W-1:0]                  hi_rdata;
  logic [ADDR_W-1:0]               raddr;

  logic [W-1:0] acc_twos_lo, acc_twos_hi, acc_ones_lo, acc_ones_hi;

  assign col   = s_axis_tdata[m3mv_pkg::COL_LSB +: m3mv_pkg::COL_BITS];
  assign half  = s_axis_tdata[m3mv_pkg::HALF_LSB];
  assign tw_in = s_axis_tdata[m3mv_pkg::TWOS_LSB +: W];
  assign on_in = s_axis_tdata[m3mv_pkg::ONES_LSB +: W];

  assign accept     = s_axis_tvalid & s_axis_tready;
  assign load_fire  = accept & (m3mv_pkg::opcode_t'(s_axis_tuser) == m3mv_pkg::OP_LOAD);
  assign eval_start = accept & (m3mv_pkg::opcode_t'(s_axis_tuser) == m3mv_pkg::OP_EVAL);

  always_comb begin
    for (int i = 0; i < W; i++) begin
      lo_mask[i] = (i < ROWS);
      hi_mask[i] = (i + W < ROWS);
    end
  end

  assign col_ok   = (32'(col) < COLUMNS);
  assign waddr    = ADDR_W'(col);
  assign lo_wdata = {on_in & ~tw_in & lo_mask, tw_in & ~on_in & lo_mask};
  assign hi_wdata = {on_in & ~tw_in & hi_mask, tw_in & ~on_in & hi_mask};
  assign raddr    = ADDR_W'(cnt);

  m3mv_ram #(
    .WIDTH (2 * W),
    .DEPTH (COLUMNS)
  ) u_lo_ram (
    .clk   (clk),
    .we    (load_fire & col_ok & ~half),
    .waddr (waddr),
    .wdata (lo_wdata),
    .raddr (raddr),
    .rdata (lo_rdata)
  );

  m3mv_ram #(
    .WIDTH (2 * W),
    .DEPTH (COLUMNS)
  ) u_hi_ram (
    .clk   (clk),
    .we    (load_fire & col_ok & half),
    .waddr (waddr),
    .wdata (hi_wdata),
    .raddr (raddr),
    .rdata (hi_rdata)
  );

  assign acc_ctrl.clear = eval_start;
  assign acc_ctrl.en    = rd_valid;
  assign acc_ctrl.sel   = rd_sel;

  m3mv_accum u_accum (
    .clk     (clk),
    .ctrl    (acc_ctrl),
    .lo_col  (lo_rdata),
    .hi_col  (hi_rdata),
    .twos_lo (acc_twos_lo),
    .twos_hi (acc_twos_hi),
    .ones_lo (acc_ones_lo),
    .ones_hi (acc_ones_hi)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= m3mv_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next    = state;
    s_axis_tready = 1'b0;
    out_load      = 1'b0;
    case (state)
      m3mv_pkg::ST_IDLE: begin
        s_axis_tready = 1'b1;
        if (eval_start) begin
          state_next = m3mv_pkg::ST_WALK;
        end
      end
      m3mv_pkg::ST_WALK: begin
        if (cnt == CNT_W'(WALK - 1)) begin
          state_next = m3mv_pkg::ST_FLUSH;
        end
      end
      m3mv_pkg::ST_FLUSH: begin
        state_next = m3mv_pkg::ST_DONE;
      end
      m3mv_pkg::ST_DONE: begin
        if (!m_axis_tvalid || m_axis_tready) begin
          out_load   = 1'b1;
          state_next = m3mv_pkg::ST_IDLE;
        end
      end
      default: begin
        state_next = m3mv_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rd_valid <= 1'b0;
    end else begin
      rd_valid <= (state == m3mv_pkg::ST_WALK);
    end
  end

  always_ff @(posedge clk) begin
    if (eval_start) begin
      cnt <= '0;
      vec <= s_axis_tdata[m3mv_pkg::VEC_LSB +: m3mv_pkg::VEC_BITS];
    end else if (state == m3mv_pkg::ST_WALK) begin
      cnt <= cnt + CNT_W'(1);
      vec <= vec >> 1;
    end
    rd_sel <= vec[0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (out_load) begin
      m_axis_tvalid <= 1'b1;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      m_axis_tdata <= MW'({acc_ones_hi[HB-1:0], acc_ones_lo,
                           acc_twos_hi[HB-1:0], acc_twos_lo});
    end
  end

endmodule
